// File: rtl/core/ternary_rule_policy_evaluator_core_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the ternary rule policy evaluator
// ---------------------------------------------------------------------------
`ifndef TERNARY_RULE_POLICY_EVALUATOR_CORE_ASSERT_SVH
`define TERNARY_RULE_POLICY_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TRPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trpe assertion failed");

// next-cycle implication, disabled during reset
`define TRPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trpe assertion failed");

`endif

// File: rtl/core/trpe_pkg.sv
// ---------------------------------------------------------------------------
// trpe_pkg
// shared types and codes of the ternary rule policy evaluator
// ---------------------------------------------------------------------------
package trpe_pkg;

  // item kinds
  localparam logic KIND_RULE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // trit codes (2-bit two's complement)
  localparam logic signed [1:0] TRIT_NEG  = 2'sb11;
  localparam logic signed [1:0] TRIT_NEUT = 2'sb00;
  localparam logic signed [1:0] TRIT_POS  = 2'sb01;
  localparam logic signed [1:0] TRIT_BAD  = 2'sb10;

  // requirement code that skips a field
  localparam logic [1:0] REQ_UNUSED = 2'b11;

  // combining modes
  typedef enum logic [1:0] {
    COMB_DENY   = 2'd0,
    COMB_PERMIT = 2'd1,
    COMB_FIRST  = 2'd2,
    COMB_CONS   = 2'd3
  } comb_t;

  // one table entry
  typedef struct packed {
    logic [7:0]        domain;
    logic [15:0]       mask;
    logic [31:0]       reqs;
    comb_t             combining;
    logic signed [1:0] result;
  } rule_t;

  // controller to datapath
  typedef struct packed {
    logic wr;     // store the incoming rule word
    logic start;  // latch query, clear accumulators
    logic issue;  // read table entry and advance address
    logic eval;   // table data valid, fold it in
    logic load;   // move verdict into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;  // no active rules
    logic last;   // address being issued is the last one
    logic stop;   // first-applicable hit decides the verdict
  } sts_t;

endpackage

// File: rtl/core/trpe_ram.sv
// ---------------------------------------------------------------------------
// trpe_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module trpe_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/trpe_ctrl.sv
// ---------------------------------------------------------------------------
// trpe_ctrl
// sequencer for rule writes, table walk and result handoff
// ---------------------------------------------------------------------------
`include "ternary_rule_policy_evaluator_core_assert.svh"

module trpe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  trpe_pkg::sts_t sts,
  output trpe_pkg::cmd_t cmd
);
  import trpe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   rd_pend_r, rd_pend_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.wr    = accept && (in_kind == KIND_RULE);
        cmd.start = accept && (in_kind == KIND_QUERY);
        if (cmd.start) begin
          state_nxt = sts.empty ? ST_FIN : ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        cmd.eval  = rd_pend_r;
        if (sts.stop) begin
          state_nxt = ST_FIN;
        end else if (sts.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.eval  = rd_pend_r;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.load = !out_valid_r || !out_stall;
        if (cmd.load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // read pipe and output valid
  always_comb begin
    rd_pend_nxt   = cmd.issue;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `TRPE_ASSERT_SAME(a_load_free, clk, rst_n, cmd.load, !out_valid_r || !out_stall)
  `TRPE_ASSERT_NEXT(a_stop_fin, clk, rst_n, sts.stop, state_r == ST_FIN)
  `TRPE_ASSERT_NEXT(a_start_go, clk, rst_n, cmd.start, state_r == ST_WALK || state_r == ST_FIN)

endmodule

// File: rtl/core/trpe_dp.sv
// ---------------------------------------------------------------------------
// trpe_dp
// rule table, match logic, verdict accumulator and output register
// ---------------------------------------------------------------------------
module trpe_dp #(
  parameter int MAX_RULES  = 64,
  parameter int NUM_FIELDS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  trpe_pkg::cmd_t    cmd,
  output trpe_pkg::sts_t    sts,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  input  logic [5:0]        in_rule_index,
  input  logic [15:0]       in_rule_mask,
  input  logic [31:0]       in_rule_requirements,
  input  logic [7:0]        in_rule_domain,
  input  logic [1:0]        in_rule_combining,
  input  logic signed [1:0] in_rule_result,
  input  logic [7:0]        in_query_domain,
  input  logic [31:0]       in_query_fields,
  output logic signed [1:0] out_decision
);
  import trpe_pkg::*;

  localparam int AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int SW    = CNT_W + 2;
  localparam logic [7:0] MAX8 = 8'(MAX_RULES);

  logic [6:0]          cnt_r;
  logic [7:0]          qdom_r;
  logic [31:0]         qfld_r;
  logic [CNT_W-1:0]    lim_r, lim_nxt;
  logic [CNT_W-1:0]    addr_r;
  logic                any_r;
  comb_t               mode_r;
  logic signed [1:0]   verdict_r, verdict_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic signed [1:0]   out_dec_r;
  logic signed [SW-1:0] res_ext;
  rule_t               wr_rule, rd_rule;
  logic                wr_ok, fields_ok, hit;

  // active rule count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_wr_en) begin
      cnt_r <= cfg_wr_data;
    end
  end

  // rule word to store, deny code folds the unused result encoding
  always_comb begin
    wr_rule.domain    = in_rule_domain;
    wr_rule.mask      = in_rule_mask;
    wr_rule.reqs      = in_rule_requirements;
    wr_rule.combining = comb_t'(in_rule_combining);
    wr_rule.result    = (in_rule_result == TRIT_BAD) ? TRIT_NEG : in_rule_result;
    wr_ok             = ({2'b00, in_rule_index} < MAX8);
  end

  trpe_ram #(
    .WIDTH($bits(rule_t)),
    .DEPTH(MAX_RULES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr && wr_ok),
    .waddr (AW'(in_rule_index)),
    .wdata (wr_rule),
    .raddr (addr_r[AW-1:0]),
    .rdata (rd_rule)
  );

  // clamp the count to the table depth
  always_comb begin
    if ({1'b0, cnt_r} >= MAX8) begin
      lim_nxt = CNT_W'(MAX_RULES);
    end else begin
      lim_nxt = CNT_W'(cnt_r);
    end
  end

  // field match of the entry just read
  always_comb begin
    fields_ok = 1'b1;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      if (rd_rule.mask[f] && (rd_rule.reqs[2*f +: 2] != REQ_UNUSED) &&
          (qfld_r[2*f +: 2] != (rd_rule.reqs[2*f +: 2] - 2'd1))) begin
        fields_ok = 1'b0;
      end
    end
    hit = cmd.eval && (rd_rule.domain == qdom_r) && fields_ok;
  end

  assign sts.empty = (cnt_r == 7'd0);
  assign sts.last  = (addr_r == (lim_r - CNT_W'(1)));
  assign sts.stop  = hit && !any_r && (rd_rule.combining == COMB_FIRST);

  // verdict update for a matching entry
  always_comb begin
    res_ext     = {{(SW-2){rd_rule.result[1]}}, rd_rule.result};
    verdict_nxt = verdict_r;
    sum_nxt     = sum_r;
    if (!any_r) begin
      verdict_nxt = rd_rule.result;
      sum_nxt     = res_ext;
    end else begin
      case (mode_r)
        COMB_DENY: begin
          if (rd_rule.result < verdict_r) begin
            verdict_nxt = rd_rule.result;
          end
        end
        COMB_PERMIT: begin
          if (rd_rule.result > verdict_r) begin
            verdict_nxt = rd_rule.result;
          end
        end
        COMB_CONS: begin
          sum_nxt = sum_r + res_ext;
          if (sum_nxt[SW-1]) begin
            verdict_nxt = TRIT_NEG;
          end else if (sum_nxt == '0) begin
            verdict_nxt = TRIT_NEUT;
          end else begin
            verdict_nxt = TRIT_POS;
          end
        end
        default: begin
          verdict_nxt = verdict_r;
        end
      endcase
    end
  end

  // walk state and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      any_r  <= 1'b0;
    end else if (cmd.start) begin
      addr_r <= '0;
      any_r  <= 1'b0;
    end else begin
      if (cmd.issue) begin
        addr_r <= addr_r + CNT_W'(1);
      end
      if (hit) begin
        any_r <= 1'b1;
      end
    end
  end

  // query payload and verdict
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qdom_r    <= in_query_domain;
      qfld_r    <= in_query_fields;
      lim_r     <= lim_nxt;
      verdict_r <= TRIT_NEG;
      sum_r     <= '0;
      mode_r    <= COMB_DENY;
    end else if (hit) begin
      verdict_r <= verdict_nxt;
      sum_r     <= sum_nxt;
      if (!any_r) begin
        mode_r <= rd_rule.combining;
      end
    end
    if (cmd.load) begin
      out_dec_r <= verdict_r;
    end
  end

  assign out_decision = out_dec_r;

endmodule

// File: rtl/core/ternary_rule_policy_evaluator_core.sv
// ---------------------------------------------------------------------------
// ternary_rule_policy_evaluator_core
// rule table with ternary field match and policy combining of the verdicts
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in      | input     | in_valid / in_stall   | rule write or query
//  out     | output    | out_valid / out_stall | decision
//  cfg     | input     | cfg_wr_en             | active rule count
//
// a query holds the input while it walks N = min(count, MAX_RULES) table
// entries, skips the walk with no active rules, and ends early on a
// first-applicable hit; the walk reads one table entry a cycle through the
// ram read port. reset is synchronous and clears control and the count;
// table entries are undefined until written. a finished verdict waits in
// the output register while the next word is taken.
module ternary_rule_policy_evaluator_core #(
  parameter int MAX_RULES  = 64,
  parameter int NUM_FIELDS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [5:0]        in_rule_index,
  input  logic [15:0]       in_rule_mask,
  input  logic [31:0]       in_rule_requirements,
  input  logic [7:0]        in_rule_domain,
  input  logic [1:0]        in_rule_combining,
  input  logic signed [1:0] in_rule_result,
  input  logic [7:0]        in_query_domain,
  input  logic [31:0]       in_query_fields,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [1:0] out_decision
);
  import trpe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  trpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  trpe_dp #(
    .MAX_RULES  (MAX_RULES),
    .NUM_FIELDS (NUM_FIELDS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_rule_index        (in_rule_index),
    .in_rule_mask         (in_rule_mask),
    .in_rule_requirements (in_rule_requirements),
    .in_rule_domain       (in_rule_domain),
    .in_rule_combining    (in_rule_combining),
    .in_rule_result       (in_rule_result),
    .in_query_domain      (in_query_domain),
    .in_query_fields      (in_query_fields),
    .out_decision         (out_decision)
  );

endmodule
